>>> rtl/core/sld_pkg.sv
// shared types and constants for the sync length frame deframer
package sld_pkg;

  localparam int unsigned SYNC_BYTES   = 4;
  localparam int unsigned LENGTH_BYTES = 8;
  localparam int unsigned APB_AW       = 3;

  localparam logic [APB_AW-1:0] REG_SYNC_WORD = APB_AW'(0);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_HEAD = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       section;
    logic       section_last;
    logic       frame_last;
    logic       length_error;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } result_t;

endpackage

>>> rtl/core/sld_stream_if.sv
// valid/ready stream interface carrying one beat
interface sld_stream_if #(
  parameter type payload_t = sld_pkg::in_beat_t
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sync_length_frame_deframer_core.sv
// top level of the sync length frame deframer
//
//   port      dir   beat           notes
//   in_i      sink  in_beat_t      one received byte per beat
//   out_o     src   out_beat_t     header or body byte, empty or error result
//   apb       in    32-bit data    sync word at byte address 0
//
// one byte per cycle sustained while out_o.ready stays high; each beat is parsed in the cycle it is taken
// results are written into a single output register as their byte is taken
// in_i.ready drops only while a result waits and out_o.ready is low
// async active-low reset returns to sync hunt with sync word zero
module sync_length_frame_deframer_core #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sld_stream_if.sink                  in_i,
  sld_stream_if.source                out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sld_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sld_pkg::*;

  logic      step;
  logic      in_ready;
  logic      out_valid;
  logic [31:0] sync_word;
  result_t   res;
  out_beat_t out_beat;

  assign in_i.ready  = in_ready;
  assign step        = in_i.valid && in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_beat;

  sld_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .sync_word_o (sync_word)
  );

  sld_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_byte_i   (in_i.data.in_byte),
    .sync_word_i (sync_word),
    .res_o       (res)
  );

  sld_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_beat_o  (out_beat),
    .in_ready_o  (in_ready)
  );
endmodule

>>> rtl/core/sld_cfg_regs.sv
// apb register file holding the sync word
module sld_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sld_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 sync_word_o
);
  import sld_pkg::*;

  logic [31:0] sync_word_q;
  logic        sel_sync;
  logic        wr_en;

  assign sel_sync = (paddr[APB_AW-1:2] == REG_SYNC_WORD[APB_AW-1:2]);
  assign wr_en    = psel && penable && pwrite && sel_sync;
  assign pready   = 1'b1;
  assign prdata   = sel_sync ? sync_word_q : 32'd0;
  assign sync_word_o = sync_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= 32'd0;
    end else if (wr_en) begin
      sync_word_q <= pwdata;
    end
  end
endmodule

>>> rtl/core/sld_parser.sv
// frame parser: sync hunt, length capture and section tagging
module sld_parser #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       in_byte_i,
  input  logic [31:0]      sync_word_i,
  output sld_pkg::result_t res_o
);
  import sld_pkg::*;

  phase_e              phase_q, phase_d;
  logic [23:0]         win_q, win_d;
  logic [1:0]          fill_q, fill_d;
  logic [55:0]         len_q, len_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [LEN_BITS-1:0] hrem_q, hrem_d;
  logic [LEN_BITS-1:0] brem_q, brem_d;

  logic [31:0]         total;
  logic [31:0]         head;
  logic [32:0]         head_min;
  logic [31:0]         body_full;
  logic [LEN_BITS-1:0] head_len;
  logic [LEN_BITS-1:0] body_len;
  logic                len_bad;
  logic                last;

  // lengths complete with the byte now arriving
  assign total     = len_q[31:0];
  assign head      = {in_byte_i, len_q[55:32]};
  assign head_min  = {1'b0, head} + 33'(LENGTH_BYTES);
  assign body_full = total - head - 32'(LENGTH_BYTES);
  assign head_len  = head[LEN_BITS-1:0];
  assign body_len  = body_full[LEN_BITS-1:0];
  assign len_bad   = ((total >> LEN_BITS) != 32'd0) || ((head >> LEN_BITS) != 32'd0) ||
                     ({1'b0, total} < head_min);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      win_q   <= '0;
      fill_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      hrem_q  <= '0;
      brem_q  <= '0;
    end else begin
      phase_q <= phase_d;
      win_q   <= win_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      hrem_q  <= hrem_d;
      brem_q  <= brem_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    fill_d  = fill_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    hrem_d  = hrem_q;
    brem_d  = brem_q;
    res_o   = '0;
    last    = 1'b0;
    if (step_i) begin
      case (phase_q)
        PH_HUNT: begin
          win_d = {in_byte_i, win_q[23:8]};
          if (fill_q == 2'd3) begin
            if ({in_byte_i, win_q} == sync_word_i) begin
              phase_d = PH_LEN;
              win_d   = '0;
              fill_d  = '0;
              len_d   = '0;
              cnt_d   = '0;
            end
          end else begin
            fill_d = fill_q + 2'd1;
          end
        end
        PH_LEN: begin
          if (cnt_q != 3'(LENGTH_BYTES - 1)) begin
            len_d = {in_byte_i, len_q[55:8]};
            cnt_d = cnt_q + 3'd1;
          end else begin
            len_d = '0;
            cnt_d = '0;
            if (len_bad) begin
              res_o.valid             = 1'b1;
              res_o.beat.frame_last   = 1'b1;
              res_o.beat.length_error = 1'b1;
              phase_d = PH_HUNT;
              win_d   = '0;
              fill_d  = '0;
            end else begin
              hrem_d = head_len;
              brem_d = body_len;
              if ((head_len == '0) && (body_len == '0)) begin
                res_o.valid           = 1'b1;
                res_o.beat.frame_last = 1'b1;
                phase_d = PH_HUNT;
                win_d   = '0;
                fill_d  = '0;
              end else if (head_len != '0) begin
                phase_d = PH_HEAD;
              end else begin
                phase_d = PH_BODY;
              end
            end
          end
        end
        PH_HEAD: begin
          last = (hrem_q <= LEN_BITS'(1));
          res_o.valid             = 1'b1;
          res_o.beat.out_byte     = in_byte_i;
          res_o.beat.has_data     = 1'b1;
          res_o.beat.section_last = last;
          res_o.beat.frame_last   = last && (brem_q == '0);
          hrem_d = last ? '0 : hrem_q - LEN_BITS'(1);
          if (last) begin
            if (brem_q != '0) begin
              phase_d = PH_BODY;
            end else begin
              phase_d = PH_HUNT;
              win_d   = '0;
              fill_d  = '0;
            end
          end
        end
        default: begin
          last = (brem_q <= LEN_BITS'(1));
          res_o.valid             = 1'b1;
          res_o.beat.out_byte     = in_byte_i;
          res_o.beat.has_data     = 1'b1;
          res_o.beat.section      = 1'b1;
          res_o.beat.section_last = last;
          res_o.beat.frame_last   = last;
          brem_d = last ? '0 : brem_q - LEN_BITS'(1);
          if (last) begin
            phase_d = PH_HUNT;
            win_d   = '0;
            fill_d  = '0;
          end
        end
      endcase
    end
  end

  a_len_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_LEN) && (cnt_q != 3'(LENGTH_BYTES - 1))) |-> !res_o.valid)
    else $error("result during length capture");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.beat.has_data) |-> res_o.beat.frame_last)
    else $error("dataless result does not end frame");

  a_head_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEAD) |-> (hrem_q != '0))
    else $error("header phase with nothing left");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (brem_q != '0))
    else $error("body phase with nothing left");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_HUNT) && (fill_q != 2'd3)) |=> (fill_q == $past(fill_q) + 2'd1))
    else $error("window fill did not advance");
endmodule

>>> rtl/core/sld_out_reg.sv
// result register between parser and output channel
module sld_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sld_pkg::result_t   res_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output sld_pkg::out_beat_t out_beat_o,
  output logic               in_ready_o
);
  import sld_pkg::*;

  logic      valid_q, valid_d;
  out_beat_t beat_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (res_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      beat_q <= res_i.beat;
    end
  end
endmodule

>>> tb/sv/tb_sync_length_frame_deframer_core.sv
// self-checking testbench for the sync length frame deframer: framed byte streams in, beats checked
module tb_sync_length_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sld_pkg::*;

  localparam int unsigned LEN_BITS    = 32;
  localparam logic [32:0] LEN_MAX     = (33'd1 << LEN_BITS) - 33'd1;
  localparam int          LAT         = 4;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          RAND_BEATS  = 1100;

  class frame_scoreboard;
    logic [31:0] sync_word;
    phase_e      phase;
    logic [23:0] window;
    logic [1:0]  fill;
    logic [63:0] len_acc;
    logic [2:0]  len_cnt;
    logic [31:0] head_left;
    logic [31:0] body_left;
    out_beat_t   expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned frames_done;
    int unsigned length_errors;
    int unsigned empty_frames;

    function new();
      sync_word = '0;
      go_hunt();
      len_acc = '0;
      len_cnt = '0;
      head_left = '0;
      body_left = '0;
    endfunction

    function void go_hunt();
      phase = PH_HUNT;
      window = '0;
      fill = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      logic [31:0] cand;
      logic [32:0] total;
      logic [32:0] head;
      logic        last;
      out_beat_t   r;
      r = '0;
      case (phase)
        PH_HUNT: begin
          if (fill == 2'd3) begin
            cand = {b, window};
            if (cand == sync_word) begin
              phase = PH_LEN;
              window = '0;
              fill = '0;
              len_acc = '0;
              len_cnt = '0;
            end else begin
              window = cand[31:8];
            end
          end else begin
            window = window | (24'(b) << (8 * fill));
            fill = fill + 2'd1;
          end
        end
        PH_LEN: begin
          len_acc = len_acc | (64'(b) << (8 * len_cnt));
          if (len_cnt != 3'd7) begin
            len_cnt = len_cnt + 3'd1;
          end else begin
            len_cnt = '0;
            total = {1'b0, len_acc[31:0]};
            head = {1'b0, len_acc[63:32]};
            len_acc = '0;
            if (total > LEN_MAX || head > LEN_MAX || total < head + 33'd8) begin
              r.frame_last = 1'b1;
              r.length_error = 1'b1;
              expected_q.push_back(r);
              length_errors++;
              go_hunt();
            end else begin
              head_left = head[31:0];
              body_left = 32'(total - head - 33'd8);
              if (head_left == 0 && body_left == 0) begin
                r.frame_last = 1'b1;
                expected_q.push_back(r);
                empty_frames++;
                go_hunt();
              end else if (head_left != 0) begin
                phase = PH_HEAD;
              end else begin
                phase = PH_BODY;
              end
            end
          end
        end
        PH_HEAD: begin
          last = (head_left <= 1);
          r.out_byte = b;
          r.has_data = 1'b1;
          r.section_last = last;
          r.frame_last = last && (body_left == 0);
          expected_q.push_back(r);
          head_left = last ? 32'd0 : head_left - 32'd1;
          if (last) begin
            if (body_left != 0) begin
              phase = PH_BODY;
            end else begin
              go_hunt();
            end
          end
        end
        default: begin
          last = (body_left <= 1);
          r.out_byte = b;
          r.has_data = 1'b1;
          r.section = 1'b1;
          r.section_last = last;
          r.frame_last = last;
          expected_q.push_back(r);
          body_left = last ? 32'd0 : body_left - 32'd1;
          if (last) go_hunt();
        end
      endcase
    endfunction

    function void flag_field(string field, logic [7:0] e, logic [7:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, field, e, a);
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp_beat;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none actual %h", $time, got);
        return;
      end
      exp_beat = expected_q.pop_front();
      checked++;
      if (exp_beat.frame_last) frames_done++;
      flag_field("out_byte", exp_beat.out_byte, got.out_byte);
      flag_field("has_data", 8'(exp_beat.has_data), 8'(got.has_data));
      flag_field("section", 8'(exp_beat.section), 8'(got.section));
      flag_field("section_last", 8'(exp_beat.section_last), 8'(got.section_last));
      flag_field("frame_last", 8'(exp_beat.frame_last), 8'(got.frame_last));
      flag_field("length_error", 8'(exp_beat.length_error), 8'(got.length_error));
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        errors++;
        $display("%0t: beats left over, expected %0d actual 0", $time, expected_q.size());
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sld_stream_if #(.payload_t(in_beat_t))  in_if ();
  sld_stream_if #(.payload_t(out_beat_t)) out_if ();

  sync_length_frame_deframer_core #(.LEN_BITS(LEN_BITS)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_scoreboard sb = new();

  bit          tx_gaps;
  bit          rx_stalls;
  int unsigned beats_sent;
  int unsigned noise_beats;
  int unsigned sync_writes;
  int          cycle_count;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_byte(in_if.data.in_byte);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps || r < 50) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic int pick_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  // sink side: ready held high or low for random stretches
  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (!rx_stalls || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
        hold = $urandom_range(0, 5);
      end else begin
        out_if.ready <= 1'b0;
        hold = pick_hold();
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("sync_length_frame_deframer_core: mismatch");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
  endtask

  // noise byte that shares no value with the sync word
  task automatic send_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == sb.sync_word[7:0] || b == sb.sync_word[15:8] ||
           b == sb.sync_word[23:16] || b == sb.sync_word[31:24]);
    send_byte(b);
    noise_beats++;
  endtask

  task automatic send_sync(input int n);
    for (int i = 0; i < n; i++) send_byte(sb.sync_word[8*i +: 8]);
  endtask

  task automatic send_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) send_byte(v[8*i +: 8]);
  endtask

  // stop sending until every expected beat is out and the block is quiet
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [31:0] total, input logic [31:0] head,
                            input int npay, input int noise_n, input bit extreme_pay,
                            input bit pause);
    repeat (noise_n) send_noise();
    send_sync(4);
    send_le32(total);
    if (pause) drain();
    send_le32(head);
    for (int i = 0; i < npay; i++) begin
      if (extreme_pay) send_byte((i % 2) ? 8'hFF : 8'h00);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_sync(input logic [31:0] w);
    logic [31:0] rd;
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SYNC_WORD;
    pwdata <= w;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.sync_word = w;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== w) begin
      sb.errors++;
      $display("%0t: sync_word readback expected %h actual %h", $time, w, rd);
    end
    sync_writes++;
  endtask

  function automatic int pick_len(int lo_hi, int mid_hi, int big_lo, int big_hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, lo_hi);
    if (r < 97) return $urandom_range(0, mid_hi);
    return $urandom_range(big_lo, big_hi);
  endfunction

  initial begin
    int          kind;
    int          h;
    int          bl;
    int          goal;
    logic [31:0] tot;
    logic [31:0] hd;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    beats_sent = 0;
    noise_beats = 0;
    sync_writes = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, on the reset sync word of zero
    send_frame(32'd8, 32'd0, 0, 0, 1'b0, 1'b0);
    send_frame(32'd7, 32'd0, 0, 2, 1'b0, 1'b0);
    send_frame(32'd0, 32'd0, 0, 0, 1'b0, 1'b0);
    send_frame(32'd11, 32'd3, 3, 0, 1'b1, 1'b0);
    send_frame(32'd13, 32'd0, 5, 1, 1'b1, 1'b0);
    send_frame(32'd10, 32'd1, 2, 0, 1'b0, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFF8, 0, 0, 1'b0, 1'b0);
    send_frame(32'd14, 32'd2, 4, 0, 1'b0, 1'b0);

    write_sync(32'hFFFF_FFFF);
    repeat (3) send_noise();
    send_sync(2);
    send_noise();
    send_frame(32'd10, 32'd0, 2, 0, 1'b1, 1'b0);

    // sync word changed while the length bytes are being taken
    send_sync(4);
    send_le32(32'd12);
    write_sync(32'h5AA5_C33C);
    send_le32(32'd2);
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    send_frame(32'd9, 32'd1, 1, 0, 1'b0, 1'b0);

    // sync pattern that overlaps itself, preceded by two of its own bytes
    write_sync(32'h0201_0101);
    send_byte(8'h01);
    send_byte(8'h01);
    send_frame(32'd9, 32'd0, 1, 0, 1'b0, 1'b0);

    // sync word changed while the hunt window is part filled
    send_byte(8'h01);
    send_byte(8'h01);
    write_sync(32'hA55A_3CC3);
    send_frame(32'd11, 32'd2, 3, 0, 1'b0, 1'b0);

    // random frames across several sync words
    goal = (beats_sent - noise_beats) + RAND_BEATS;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_sync($urandom);
        1: write_sync(32'h0000_0000);
        2: write_sync(32'hFFFF_FFFF);
        3: write_sync({4{8'($urandom_range(0, 255))}});
        default: write_sync($urandom);
      endcase
      tx_gaps = (p != 1);
      rx_stalls = (p != 1) && (p != 3);
      while ((beats_sent - noise_beats) < goal - (4 - p) * (RAND_BEATS / 5)) begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          case ($urandom_range(0, 2))
            0: begin
              hd = $urandom_range(0, 20);
              tot = $urandom_range(0, hd + 7);
            end
            1: begin
              hd = $urandom | 32'h1;
              tot = $urandom_range(0, hd - 1);
            end
            default: begin
              hd = '0;
              tot = $urandom_range(0, 7);
            end
          endcase
          send_frame(tot, hd, 0, $urandom_range(0, 2), 1'b0, 1'b0);
        end else if (kind < 13) begin
          send_frame(32'd8, 32'd0, 0, $urandom_range(0, 2), 1'b0, 1'b0);
        end else if (kind < 17) begin
          send_sync($urandom_range(1, 3));
          send_noise();
        end else begin
          h = pick_len(6, 20, 50, 120);
          bl = pick_len(16, 48, 150, 400);
          send_frame(32'(h + bl + 8), 32'(h), h + bl,
                     ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : 0,
                     1'b0, $urandom_range(0, 29) == 0);
        end
      end
    end

    drain();
    repeat (LAT) @(posedge clk_i);
    sb.close_out();
    $display("covered %0d input beats (%0d noise), %0d sync word writes",
             beats_sent, noise_beats, sync_writes);
    $display("checked %0d beats over %0d frames, %0d length errors, %0d empty frames",
             sb.checked, sb.frames_done, sb.length_errors, sb.empty_frames);
    if (sb.errors == 0) begin
      $display("sync_length_frame_deframer_core: match");
    end else begin
      $display("sync_length_frame_deframer_core: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sld_pkg.sv
rtl/core/sld_stream_if.sv
rtl/core/sld_cfg_regs.sv
rtl/core/sld_parser.sv
rtl/core/sld_out_reg.sv
rtl/core/sync_length_frame_deframer_core.sv
tb/sv/tb_sync_length_frame_deframer_core.sv
